FILE: hdl/battery_ocv_bilinear_lookup_unit_defines.svh
// Assertion macros used by the checker of the OCV lookup unit.
// No dependencies; included by the checker module.
`ifndef BATTERY_OCV_BILINEAR_LOOKUP_UNIT_DEFINES_SVH
`define BATTERY_OCV_BILINEAR_LOOKUP_UNIT_DEFINES_SVH

// Condition and consequence in the same cycle.
`define BOLU_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequence in the cycle after the condition.
`define BOLU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Invariant that holds in every cycle out of reset.
`define BOLU_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

`endif

FILE: hdl/bolu_pkg.sv
// Types, constants and the voltage table of the OCV bilinear lookup unit.
// No dependencies; used by all RTL files but bolu_if, and by the checker.
package bolu_pkg;

   typedef logic [14:0] soc_type;
   typedef logic [9:0]  temp_type;
   typedef logic [3:0]  col_type;
   typedef logic [1:0]  row_idx_type;
   typedef logic [11:0] sfrac_type;
   typedef logic [8:0]  tfrac_type;
   typedef logic [12:0] mv_type;
   typedef logic [23:0] lerp_type;
   typedef logic [32:0] acc_type;
   typedef logic [20:0] quot_type;
   typedef logic [21:0] recip_type;
   typedef logic [42:0] recip_prod_type;
   typedef logic [15:0] ocv_type;

   localparam int SocCols  = 11;
   localparam int TempRows = 3;

   localparam soc_type   SocMaxQ8   = 15'd25600;
   localparam temp_type  TempMaxQ4  = 10'd800;
   localparam sfrac_type SocSeg     = 12'd2560;
   localparam tfrac_type TempSeg    = 9'd400;
   localparam col_type   LastCol    = 4'd9;
   localparam acc_type   RoundBias  = 33'd51200;
   localparam int        QuotShift  = 12;
   localparam int        RecipShift = 26;
   localparam recip_type Recip25    = 22'd2684355;
   localparam int        PipeDepth  = 6;

   localparam mv_type OcvRomMv [TempRows][SocCols] = '{
      '{13'd3000, 13'd3300, 13'd3450, 13'd3550, 13'd3650, 13'd3700,
        13'd3750, 13'd3850, 13'd3950, 13'd4050, 13'd4150},
      '{13'd3100, 13'd3400, 13'd3550, 13'd3650, 13'd3720, 13'd3800,
        13'd3900, 13'd4000, 13'd4050, 13'd4120, 13'd4200},
      '{13'd3150, 13'd3450, 13'd3580, 13'd3680, 13'd3750, 13'd3850,
        13'd3950, 13'd4030, 13'd4100, 13'd4170, 13'd4220}
   };

   typedef struct packed {
      soc_type  soc;
      temp_type temp;
      col_type  col;
      logic     row;
   } seg_type;

   typedef struct packed {
      mv_type    v00;
      mv_type    v01;
      mv_type    v10;
      mv_type    v11;
      sfrac_type fs;
      tfrac_type ft;
   } corner_type;

   typedef struct packed {
      lerp_type  lo;
      lerp_type  hi;
      tfrac_type ft;
   } lerp_pair_type;

endpackage

FILE: hdl/bolu_if.sv
// Valid/ready channel interfaces for the request and response words.
// No dependencies.
interface bolu_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] soc_q8;
   logic signed [11:0] temp_q4;

   modport source (output valid, soc_q8, temp_q4, input ready);
   modport sink (input valid, soc_q8, temp_q4, output ready);
endinterface

interface bolu_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] ocv_tenth_mv;

   modport source (output valid, ocv_tenth_mv, input ready);
   modport sink (input valid, ocv_tenth_mv, output ready);
endinterface

FILE: hdl/battery_ocv_bilinear_lookup_unit.sv
// Battery open-circuit voltage lookup by bilinear interpolation over a 3x11 table.
// Depends on bolu_pkg, bolu_if, bolu_front, bolu_interp and bolu_scale.
// An accepted request word moves through the six stage registers to its response.
// One word per cycle while rsp_bus is ready; each stage holds its own valid bit.
// A stalled stage only holds up the stages behind it, so bubbles are squeezed out.
// Synchronous reset clears all valid bits; the data registers are not reset.
module battery_ocv_bilinear_lookup_unit (
   input logic       clock,
   input logic       reset,
   bolu_req_if.sink  req_bus,
   bolu_rsp_if.source rsp_bus
);

   logic                 fr_valid;
   logic                 fr_ready;
   bolu_pkg::corner_type fr_data;
   logic                 ip_valid;
   logic                 ip_ready;
   bolu_pkg::acc_type    ip_data;

   bolu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_soc    (req_bus.soc_q8),
      .in_temp   (req_bus.temp_q4),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_data  (fr_data)
   );

   bolu_interp u_interp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_data   (fr_data),
      .out_valid (ip_valid),
      .out_ready (ip_ready),
      .out_data  (ip_data)
   );

   bolu_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ip_valid),
      .in_ready  (ip_ready),
      .in_data   (ip_data),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (rsp_bus.ocv_tenth_mv)
   );

endmodule

FILE: hdl/bolu_front.sv
// Front two pipeline stages: input clamping, segment selection, weights and table reads.
// Depends on bolu_pkg.
module bolu_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic signed [15:0]    in_soc,
   input  logic signed [11:0]    in_temp,
   output logic                  out_valid,
   input  logic                  out_ready,
   output bolu_pkg::corner_type  out_data
);

   logic                 va_ff;
   logic                 vb_ff;
   logic                 en_a;
   logic                 en_b;
   bolu_pkg::soc_type    soc_c;
   bolu_pkg::temp_type   temp_c;
   bolu_pkg::seg_type    seg_in;
   bolu_pkg::seg_type    seg_ff;
   bolu_pkg::corner_type crn_in;
   bolu_pkg::corner_type crn_ff;
   bolu_pkg::row_idx_type row_lo;
   bolu_pkg::row_idx_type row_hi;
   bolu_pkg::col_type    col_hi;

   assign en_b     = !vb_ff || out_ready;
   assign en_a     = !va_ff || en_b;
   assign in_ready = en_a;

   always_comb begin
      if (in_soc[15]) begin
         soc_c = '0;
      end else if (in_soc[14:0] > bolu_pkg::SocMaxQ8) begin
         soc_c = bolu_pkg::SocMaxQ8;
      end else begin
         soc_c = in_soc[14:0];
      end
      if (in_temp[11]) begin
         temp_c = '0;
      end else if (in_temp[10:0] > 11'(bolu_pkg::TempMaxQ4)) begin
         temp_c = bolu_pkg::TempMaxQ4;
      end else begin
         temp_c = in_temp[9:0];
      end
   end

   always_comb begin
      seg_in      = '0;
      seg_in.soc  = soc_c;
      seg_in.temp = temp_c;
      for (int k = 1; k <= int'(bolu_pkg::LastCol); k++) begin
         if (soc_c >= bolu_pkg::soc_type'(k * int'(bolu_pkg::SocSeg))) begin
            seg_in.col = bolu_pkg::col_type'(k);
         end
      end
      seg_in.row = (temp_c >= bolu_pkg::temp_type'(bolu_pkg::TempSeg));
   end

   assign row_lo = {1'b0, seg_ff.row};
   assign row_hi = row_lo + 2'd1;
   assign col_hi = seg_ff.col + 4'd1;

   always_comb begin
      crn_in.fs  = bolu_pkg::sfrac_type'(seg_ff.soc
                   - bolu_pkg::soc_type'(seg_ff.col)
                   * bolu_pkg::soc_type'(bolu_pkg::SocSeg));
      crn_in.ft  = bolu_pkg::tfrac_type'(seg_ff.temp
                   - (seg_ff.row ? bolu_pkg::temp_type'(bolu_pkg::TempSeg) : '0));
      crn_in.v00 = bolu_pkg::OcvRomMv[row_lo][seg_ff.col];
      crn_in.v01 = bolu_pkg::OcvRomMv[row_lo][col_hi];
      crn_in.v10 = bolu_pkg::OcvRomMv[row_hi][seg_ff.col];
      crn_in.v11 = bolu_pkg::OcvRomMv[row_hi][col_hi];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         if (en_a) begin
            va_ff <= in_valid;
         end
         if (en_b) begin
            vb_ff <= va_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_a && in_valid) begin
         seg_ff <= seg_in;
      end
      if (en_b && va_ff) begin
         crn_ff <= crn_in;
      end
   end

   assign out_valid = vb_ff;
   assign out_data  = crn_ff;

endmodule

FILE: hdl/bolu_interp.sv
// Middle two pipeline stages: interpolation along charge, then along temperature.
// Depends on bolu_pkg.
module bolu_interp (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  bolu_pkg::corner_type  in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output bolu_pkg::acc_type     out_data
);

   logic                    vc_ff;
   logic                    vd_ff;
   logic                    en_c;
   logic                    en_d;
   bolu_pkg::sfrac_type     ws;
   bolu_pkg::tfrac_type     wt;
   bolu_pkg::lerp_pair_type lp_in;
   bolu_pkg::lerp_pair_type lp_ff;
   bolu_pkg::acc_type       n_in;
   bolu_pkg::acc_type       n_ff;

   assign en_d     = !vd_ff || out_ready;
   assign en_c     = !vc_ff || en_d;
   assign in_ready = en_c;

   assign ws = bolu_pkg::SocSeg - in_data.fs;

   always_comb begin
      lp_in.lo = bolu_pkg::lerp_type'(in_data.v00) * bolu_pkg::lerp_type'(ws)
               + bolu_pkg::lerp_type'(in_data.v01) * bolu_pkg::lerp_type'(in_data.fs);
      lp_in.hi = bolu_pkg::lerp_type'(in_data.v10) * bolu_pkg::lerp_type'(ws)
               + bolu_pkg::lerp_type'(in_data.v11) * bolu_pkg::lerp_type'(in_data.fs);
      lp_in.ft = in_data.ft;
   end

   assign wt   = bolu_pkg::TempSeg - lp_ff.ft;
   assign n_in = bolu_pkg::acc_type'(lp_ff.lo) * bolu_pkg::acc_type'(wt)
               + bolu_pkg::acc_type'(lp_ff.hi) * bolu_pkg::acc_type'(lp_ff.ft);

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else begin
         if (en_c) begin
            vc_ff <= in_valid;
         end
         if (en_d) begin
            vd_ff <= vc_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_c && in_valid) begin
         lp_ff <= lp_in;
      end
      if (en_d && vc_ff) begin
         n_ff <= n_in;
      end
   end

   assign out_valid = vd_ff;
   assign out_data  = n_ff;

endmodule

FILE: hdl/bolu_scale.sv
// Last two pipeline stages: rounding and scaling of the weighted sum to 0.1 mV.
// Depends on bolu_pkg; the second stage is the output register of the block.
module bolu_scale (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  bolu_pkg::acc_type  in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output bolu_pkg::ocv_type  out_data
);

   logic                     ve_ff;
   logic                     vf_ff;
   logic                     en_e;
   logic                     en_f;
   bolu_pkg::acc_type        sum;
   bolu_pkg::quot_type       q_in;
   bolu_pkg::quot_type       q_ff;
   bolu_pkg::recip_prod_type prod;
   bolu_pkg::ocv_type        res_in;
   bolu_pkg::ocv_type        res_ff;

   assign en_f     = !vf_ff || out_ready;
   assign en_e     = !ve_ff || en_f;
   assign in_ready = en_e;

   // The sum over 102400 is split into a shift by 4096 and a divide by 25.
   assign sum  = in_data + bolu_pkg::RoundBias;
   assign q_in = bolu_pkg::quot_type'(sum >> bolu_pkg::QuotShift);

   assign prod   = bolu_pkg::recip_prod_type'(q_ff)
                 * bolu_pkg::recip_prod_type'(bolu_pkg::Recip25);
   assign res_in = bolu_pkg::ocv_type'(prod >> bolu_pkg::RecipShift);

   always_ff @(posedge clock) begin
      if (reset) begin
         ve_ff <= 1'b0;
         vf_ff <= 1'b0;
      end else begin
         if (en_e) begin
            ve_ff <= in_valid;
         end
         if (en_f) begin
            vf_ff <= ve_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_e && in_valid) begin
         q_ff <= q_in;
      end
      if (en_f && ve_ff) begin
         res_ff <= res_in;
      end
   end

   assign out_valid = vf_ff;
   assign out_data  = res_ff;

endmodule

FILE: hdl/bolu_checker.sv
// Port-level checker for the OCV lookup unit, bound to the top level below.
// Depends on bolu_pkg and battery_ocv_bilinear_lookup_unit_defines.svh.
`include "battery_ocv_bilinear_lookup_unit_defines.svh"

module bolu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_ocv_tenth_mv
);

   logic [3:0] inflight_ff;
   logic [3:0] inflight_in;

   assign inflight_in = inflight_ff + 4'(req_valid && req_ready) - 4'(rsp_valid && rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   `BOLU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "Response word dropped while stalled.")
   `BOLU_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_ocv_tenth_mv), "Response word changed while stalled.")
   `BOLU_ASSERT_IMPLY(a_no_orphan, clock, reset, rsp_valid, inflight_ff != 4'd0, "Response word without a pending request word.")
   `BOLU_ASSERT_ALWAYS(a_depth, clock, reset, inflight_ff <= 4'(bolu_pkg::PipeDepth), "More words in flight than pipeline stages.")

endmodule

bind battery_ocv_bilinear_lookup_unit bolu_checker u_bolu_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_ocv_tenth_mv (rsp_bus.ocv_tenth_mv)
);
